### rtl/sqtc_pkg.sv
// Package for the square transposition cipher block.
// Holds sizing constants, mode codes and the sequencer state type.
// No dependencies.
package sqtc_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned CHAR_W  = 8;
  // store/grid address
  localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
  // byte counts, 0..MAX_LEN
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  // cell positions and m*m, with headroom for pos + m
  localparam int unsigned SQ_W    = CNT_W + 2;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SIDE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

endpackage

### rtl/square_transposition_cipher_top.sv
// Top level of the square transposition cipher block.
// Depends on sqtc_pkg for constants and the state type.
//
// Usage: feed message bytes one item per cycle, the final one with last_char_i
// set. Up to MAX_LEN (64) bytes are kept; extras are dropped and flagged on
// overflow_o for every result item of that message. After the final byte the
// block works out the grid side m, walks all m*m cells once (one store read
// per valid cell), passes through a drain state to settle the last grid
// write, and then emits the n result items, each in an EMIT_RD state and then
// an EMIT_OUT state, since every output goes through the registered read port
// of the grid memory. Input is stalled from the final byte until the last
// result item is taken. mode (0 encode, 1 decode) is sampled during the cell
// walk.
module square_transposition_cipher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sqtc_pkg::CHAR_W-1:0] char_in_i,
  input  logic                        last_char_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sqtc_pkg::CHAR_W-1:0] char_out_o,
  output logic                        last_out_o,
  output logic                        overflow_o
);

  sqtc_pkg::state_e state_q, state_d;

  logic                          mode_q;
  logic [sqtc_pkg::CNT_W-1:0]    cnt_q, cnt_d;     // bytes held
  logic                          drop_q, drop_d;   // overflow on this message
  logic [sqtc_pkg::ADDR_W-1:0]   m_q, m_d;         // grid side
  logic [sqtc_pkg::SQ_W-1:0]     sq_q, sq_d;       // m*m
  logic [sqtc_pkg::ADDR_W-1:0]   col_q, col_d;     // walk column
  logic [sqtc_pkg::SQ_W-1:0]     pos_q, pos_d;     // row-major cell position
  logic [sqtc_pkg::CNT_W-1:0]    k_q, k_d;         // column-major rank of valid cell
  logic [sqtc_pkg::CNT_W-1:0]    e_q, e_d;         // emit index

  // memories
  logic [sqtc_pkg::CHAR_W-1:0]   store_mem [sqtc_pkg::MAX_LEN];
  logic [sqtc_pkg::CHAR_W-1:0]   grid_mem  [sqtc_pkg::MAX_LEN];
  logic [sqtc_pkg::CHAR_W-1:0]   store_rd_q;
  logic [sqtc_pkg::CHAR_W-1:0]   grid_rd_q;

  // delayed grid write, made in the cycle after the store read
  logic                          wr_v_q, wr_v_d;
  logic [sqtc_pkg::ADDR_W-1:0]   wr_addr_q, wr_addr_d;

  logic                          in_acc;
  logic                          out_acc;
  logic                          has_room;
  logic [sqtc_pkg::SQ_W-1:0]     n_ext;
  logic [sqtc_pkg::SQ_W-1:0]     m_ext;
  logic [sqtc_pkg::SQ_W-1:0]     pos_step;
  logic [sqtc_pkg::ADDR_W-1:0]   col_nx;
  logic                          cell_ok;
  logic                          side_done;
  logic                          walk_done;
  logic                          rd_en;
  logic [sqtc_pkg::ADDR_W-1:0]   rd_addr;
  logic                          emit_last;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign has_room  = cnt_q < sqtc_pkg::CNT_W'(sqtc_pkg::MAX_LEN);
  assign n_ext     = sqtc_pkg::SQ_W'(cnt_q);
  assign m_ext     = sqtc_pkg::SQ_W'(m_q);
  // single shared adder path for the walk: step down one row
  assign pos_step  = pos_q + m_ext;
  assign col_nx    = col_q + 1'b1;
  assign cell_ok   = pos_q < n_ext;
  assign side_done = sq_q >= n_ext;
  assign walk_done = (pos_step >= sq_q) && (col_nx == m_q);
  assign emit_last = (e_q + sqtc_pkg::CNT_W'(1)) == cnt_q;
  assign rd_en     = (state_q == sqtc_pkg::ST_WALK) && cell_ok;
  assign rd_addr   = (mode_q == sqtc_pkg::MODE_ENC) ? pos_q[sqtc_pkg::ADDR_W-1:0]
                                                    : k_q[sqtc_pkg::ADDR_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sqtc_pkg::ST_LOAD: begin
        if (in_acc && last_char_i) state_d = sqtc_pkg::ST_SIDE;
      end
      sqtc_pkg::ST_SIDE: begin
        if (side_done) state_d = sqtc_pkg::ST_WALK;
      end
      sqtc_pkg::ST_WALK: begin
        if (walk_done) state_d = sqtc_pkg::ST_DRAIN;
      end
      sqtc_pkg::ST_DRAIN:    state_d = sqtc_pkg::ST_EMIT_RD;
      sqtc_pkg::ST_EMIT_RD:  state_d = sqtc_pkg::ST_EMIT_OUT;
      sqtc_pkg::ST_EMIT_OUT: begin
        if (out_acc) state_d = emit_last ? sqtc_pkg::ST_LOAD : sqtc_pkg::ST_EMIT_RD;
      end
      default: state_d = sqtc_pkg::ST_LOAD;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != sqtc_pkg::ST_LOAD);
    out_valid_o = (state_q == sqtc_pkg::ST_EMIT_OUT);
  end

  assign char_out_o = grid_rd_q;
  assign last_out_o = emit_last;
  assign overflow_o = drop_q;

  // datapath next values
  always_comb begin
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    m_d       = m_q;
    sq_d      = sq_q;
    col_d     = col_q;
    pos_d     = pos_q;
    k_d       = k_q;
    e_d       = e_q;
    wr_v_d    = 1'b0;
    wr_addr_d = wr_addr_q;
    unique case (state_q)
      sqtc_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (has_room) cnt_d = cnt_q + 1'b1;
          else          drop_d = 1'b1;
        end
        m_d  = '0;
        sq_d = '0;
      end
      sqtc_pkg::ST_SIDE: begin
        // (m+1)^2 = m^2 + 2m + 1
        if (!side_done) begin
          sq_d = sq_q + sqtc_pkg::SQ_W'({m_q, 1'b1});
          m_d  = m_q + 1'b1;
        end
        col_d = '0;
        pos_d = '0;
        k_d   = '0;
      end
      sqtc_pkg::ST_WALK: begin
        if (cell_ok) begin
          wr_v_d    = 1'b1;
          wr_addr_d = (mode_q == sqtc_pkg::MODE_ENC) ? k_q[sqtc_pkg::ADDR_W-1:0]
                                                     : pos_q[sqtc_pkg::ADDR_W-1:0];
          k_d       = k_q + 1'b1;
        end
        if (pos_step >= sq_q) begin
          col_d = col_nx;
          pos_d = sqtc_pkg::SQ_W'(col_nx);
        end else begin
          pos_d = pos_step;
        end
        e_d = '0;
      end
      sqtc_pkg::ST_DRAIN:   ;
      sqtc_pkg::ST_EMIT_RD: ;
      sqtc_pkg::ST_EMIT_OUT: begin
        if (out_acc) begin
          e_d = e_q + 1'b1;
          if (emit_last) begin
            cnt_d  = '0;
            drop_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sqtc_pkg::ST_LOAD;
      mode_q    <= sqtc_pkg::MODE_ENC;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      m_q       <= '0;
      sq_q      <= '0;
      col_q     <= '0;
      pos_q     <= '0;
      k_q       <= '0;
      e_q       <= '0;
      wr_v_q    <= 1'b0;
      wr_addr_q <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      m_q       <= m_d;
      sq_q      <= sq_d;
      col_q     <= col_d;
      pos_q     <= pos_d;
      k_q       <= k_d;
      e_q       <= e_d;
      wr_v_q    <= wr_v_d;
      wr_addr_q <= wr_addr_d;
    end
  end

  // message store: written on load, read during the walk
  always_ff @(posedge clk_i) begin
    if (in_acc && has_room) store_mem[cnt_q[sqtc_pkg::ADDR_W-1:0]] <= char_in_i;
    if (rd_en) store_rd_q <= store_mem[rd_addr];
  end

  // grid: written behind the store read, read in order on emit
  always_ff @(posedge clk_i) begin
    if (wr_v_q) grid_mem[wr_addr_q] <= store_rd_q;
    if (state_q == sqtc_pkg::ST_EMIT_RD) grid_rd_q <= grid_mem[e_q[sqtc_pkg::ADDR_W-1:0]];
  end

`ifndef SYNTH
  // never emit past the held message
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (e_q < cnt_q))
    else $error("emit index beyond message length");

  // walk never ranks more valid cells than bytes held
  a_rank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (k_q < cnt_q))
    else $error("column-major rank beyond message length");

  // final result taken clears the message state
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_out_o) |=> (cnt_q == '0 && !drop_q && !in_stall_o))
    else $error("message state not cleared after final item");

  // side search stops at the smallest square covering the message
  a_side_minimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sqtc_pkg::ST_SIDE && side_done) |->
      (m_q == '0 || (sq_q - sqtc_pkg::SQ_W'({m_q, 1'b0}) + 1'b1) < n_ext))
    else $error("grid side not minimal");

  // byte count never exceeds capacity
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sqtc_pkg::CNT_W'(sqtc_pkg::MAX_LEN))
    else $error("byte count above capacity");
`endif

endmodule
